### rtl/tmc_uart_slave_framer_unit_assert.svh
// Assertion macros shared by the framer modules.
`ifndef TMC_UART_SLAVE_FRAMER_UNIT_ASSERT_SVH
`define TMC_UART_SLAVE_FRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define TMC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define TMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tmc_pkg.sv
// Types, codes and the CRC-8 step shared by the framer modules.
package tmc_pkg;

  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned MAX_RESULTS    = 4;
  localparam int unsigned RES_IDX_W      = $clog2(MAX_RESULTS);
  localparam int unsigned MAX_REPLY_DATA = 251;
  localparam int unsigned QDEPTH         = 2;
  localparam int unsigned QPTR_W         = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W         = $clog2(QDEPTH + 1);

  localparam logic [BYTE_W-1:0] CRC_POLY        = 8'h07;
  localparam logic [BYTE_W-1:0] RST_REQ_SYNC    = 8'hf5;
  localparam logic [BYTE_W-1:0] RST_REPLY_SYNC  = 8'h05;
  localparam logic [BYTE_W-1:0] RST_MASTER_ADDR = 8'hff;

  // Input action codes.
  localparam logic [1:0] ACT_RX    = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_DATA  = 2'd2;

  // Result kind codes.
  localparam logic [1:0] KIND_GOOD = 2'd0;
  localparam logic [1:0] KIND_BAD  = 2'd1;
  localparam logic [1:0] KIND_BYTE = 2'd2;
  localparam logic [1:0] KIND_OVF  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_REQ_SYNC    = 2'd0;
  localparam logic [1:0] CFG_REPLY_SYNC  = 2'd1;
  localparam logic [1:0] CFG_MASTER_ADDR = 2'd2;

  // One classified item: up to four results of the same kind.
  typedef struct packed {
    logic [1:0]                        kind;
    logic [BYTE_W-1:0]                 slave_addr;
    logic [BYTE_W-1:0]                 reg_num;
    logic [MAX_RESULTS-1:0][BYTE_W-1:0] bytes;
    logic [RES_IDX_W-1:0]              last_idx;
  } tmc_entry_t;

  typedef struct packed {
    logic       valid;
    tmc_entry_t entry;
  } tmc_slot_t;

  // One byte through the CRC-8 register, data bits LSB first.
  function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    logic              fb;
    c = crc;
    for (int i = 0; i < BYTE_W; i++) begin
      fb = c[BYTE_W-1] ^ b[i];
      c  = {c[BYTE_W-2:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

### rtl/tmc_front.sv
// Front end: accepts beats, tracks request and reply state, builds queue entries.
`include "tmc_uart_slave_framer_unit_assert.svh"
module tmc_front import tmc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        action_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic              final_item_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [BYTE_W-1:0] cfg_data_i,
  input  logic              q_full_i,
  output tmc_slot_t         push_o
);

  localparam logic [1:0] RX_HUNT = 2'd0;
  localparam logic [1:0] RX_ADDR = 2'd1;
  localparam logic [1:0] RX_REG  = 2'd2;
  localparam logic [1:0] RX_CRC  = 2'd3;

  logic [BYTE_W-1:0] req_sync_q, reply_sync_q, master_addr_q;
  logic [1:0]        rx_phase_q, rx_phase_d;
  logic [BYTE_W-1:0] rx_crc_q, rx_crc_d;
  logic [BYTE_W-1:0] addr_hold_q, addr_hold_d;
  logic [BYTE_W-1:0] reg_hold_q, reg_hold_d;
  logic              tx_active_q, tx_active_d;
  logic [BYTE_W-1:0] tx_crc_q, tx_crc_d;
  logic [BYTE_W-1:0] tx_count_q, tx_count_d;
  logic              accept;
  logic [BYTE_W-1:0] hdr_crc1, hdr_crc2, hdr_crc3, data_crc;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign hdr_crc1 = crc8_step('0, reply_sync_q);
  assign hdr_crc2 = crc8_step(hdr_crc1, master_addr_q);
  assign hdr_crc3 = crc8_step(hdr_crc2, data_byte_i);
  assign data_crc = crc8_step(tx_crc_q, data_byte_i);

  always_comb begin
    rx_phase_d  = rx_phase_q;
    rx_crc_d    = rx_crc_q;
    addr_hold_d = addr_hold_q;
    reg_hold_d  = reg_hold_q;
    tx_active_d = tx_active_q;
    tx_crc_d    = tx_crc_q;
    tx_count_d  = tx_count_q;
    push_o      = '0;
    if (accept) begin
      unique case (action_i)
        ACT_RX: begin
          unique case (rx_phase_q)
            RX_HUNT: begin
              if (data_byte_i == req_sync_q) begin
                rx_crc_d   = crc8_step('0, data_byte_i);
                rx_phase_d = RX_ADDR;
              end
            end
            RX_ADDR: begin
              addr_hold_d = data_byte_i;
              rx_crc_d    = crc8_step(rx_crc_q, data_byte_i);
              rx_phase_d  = RX_REG;
            end
            RX_REG: begin
              reg_hold_d = data_byte_i;
              rx_crc_d   = crc8_step(rx_crc_q, data_byte_i);
              rx_phase_d = RX_CRC;
            end
            default: begin
              push_o.valid            = 1'b1;
              push_o.entry.kind       = (data_byte_i == rx_crc_q) ? KIND_GOOD : KIND_BAD;
              push_o.entry.slave_addr = addr_hold_q;
              push_o.entry.reg_num    = reg_hold_q;
              rx_phase_d              = RX_HUNT;
              rx_crc_d                = '0;
            end
          endcase
        end
        ACT_START: begin
          // Drop any open reply and emit the header, with its CRC when the item is final.
          push_o.valid          = 1'b1;
          push_o.entry.kind     = KIND_BYTE;
          push_o.entry.bytes[0] = reply_sync_q;
          push_o.entry.bytes[1] = master_addr_q;
          push_o.entry.bytes[2] = data_byte_i;
          tx_count_d            = '0;
          if (final_item_i) begin
            push_o.entry.bytes[3] = hdr_crc3;
            push_o.entry.last_idx = RES_IDX_W'(3);
            tx_active_d           = 1'b0;
            tx_crc_d              = '0;
          end else begin
            push_o.entry.last_idx = RES_IDX_W'(2);
            tx_active_d           = 1'b1;
            tx_crc_d              = hdr_crc3;
          end
        end
        ACT_DATA: begin
          if (tx_active_q) begin
            push_o.valid = 1'b1;
            if (tx_count_q >= BYTE_W'(MAX_REPLY_DATA)) begin
              push_o.entry.kind = KIND_OVF;
              tx_active_d       = 1'b0;
              tx_crc_d          = '0;
              tx_count_d        = '0;
            end else begin
              push_o.entry.kind     = KIND_BYTE;
              push_o.entry.bytes[0] = data_byte_i;
              if (final_item_i) begin
                push_o.entry.bytes[1] = data_crc;
                push_o.entry.last_idx = RES_IDX_W'(1);
                tx_active_d           = 1'b0;
                tx_crc_d              = '0;
                tx_count_d            = '0;
              end else begin
                tx_crc_d   = data_crc;
                tx_count_d = tx_count_q + 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_sync_q    <= RST_REQ_SYNC;
      reply_sync_q  <= RST_REPLY_SYNC;
      master_addr_q <= RST_MASTER_ADDR;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_REQ_SYNC:    req_sync_q    <= cfg_data_i;
        CFG_REPLY_SYNC:  reply_sync_q  <= cfg_data_i;
        CFG_MASTER_ADDR: master_addr_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_phase_q  <= RX_HUNT;
      rx_crc_q    <= '0;
      addr_hold_q <= '0;
      reg_hold_q  <= '0;
      tx_active_q <= 1'b0;
      tx_crc_q    <= '0;
      tx_count_q  <= '0;
    end else begin
      rx_phase_q  <= rx_phase_d;
      rx_crc_q    <= rx_crc_d;
      addr_hold_q <= addr_hold_d;
      reg_hold_q  <= reg_hold_d;
      tx_active_q <= tx_active_d;
      tx_crc_q    <= tx_crc_d;
      tx_count_q  <= tx_count_d;
    end
  end

  `TMC_ASSERT_NOW(a_hunt_crc_clear, rx_phase_q == RX_HUNT, rx_crc_q == '0, "rx crc not clear while hunting")
  `TMC_ASSERT_NOW(a_count_bound, 1'b1, tx_count_q <= BYTE_W'(MAX_REPLY_DATA), "reply data count out of range")
  `TMC_ASSERT_NOW(a_idle_reply_clear, !tx_active_q, (tx_crc_q == '0) && (tx_count_q == '0), "closed reply left state behind")

endmodule

### rtl/tmc_queue.sv
// Short entry queue between front end and result serializer.
`include "tmc_uart_slave_framer_unit_assert.svh"
module tmc_queue import tmc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  tmc_slot_t push_i,
  output logic      full_o,
  output tmc_slot_t head_o,
  input  logic      pop_i
);

  tmc_entry_t        mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o       = cnt_q == QCNT_W'(QDEPTH);
  assign head_o.valid = cnt_q != '0;
  assign head_o.entry = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `TMC_ASSERT_NOW(a_no_push_full, push_i.valid, !full_o, "entry pushed into full queue")
  `TMC_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= QCNT_W'(QDEPTH), "queue count overran depth")

endmodule

### rtl/tmc_back.sv
// Back end: walks queue entries and loads one result per beat into the output register.
`include "tmc_uart_slave_framer_unit_assert.svh"
module tmc_back import tmc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tmc_slot_t         head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        kind_o,
  output logic [BYTE_W-1:0] slave_addr_o,
  output logic [BYTE_W-1:0] reg_num_o,
  output logic [BYTE_W-1:0] tx_byte_o,
  output logic              run_last_o
);

  logic                 out_valid_q;
  logic [1:0]           kind_q;
  logic [BYTE_W-1:0]    slave_addr_q, reg_num_q, tx_byte_q;
  logic                 run_last_q;
  logic [RES_IDX_W-1:0] pos_q, pos_d;
  logic                 load, at_last;

  assign load    = head_i.valid && (!out_valid_q || out_ready_i);
  assign at_last = pos_q == head_i.entry.last_idx;
  assign pop_o   = load && at_last;
  assign pos_d   = at_last ? '0 : pos_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pos_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        pos_q       <= pos_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q       <= head_i.entry.kind;
      slave_addr_q <= head_i.entry.slave_addr;
      reg_num_q    <= head_i.entry.reg_num;
      tx_byte_q    <= head_i.entry.bytes[pos_q];
      run_last_q   <= at_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign slave_addr_o = slave_addr_q;
  assign reg_num_o    = reg_num_q;
  assign tx_byte_o    = tx_byte_q;
  assign run_last_o   = run_last_q;

  `TMC_ASSERT_NEXT(a_pos_rewind, pop_o, pos_q == '0, "result index not rewound after entry")
  `TMC_ASSERT_NOW(a_mid_entry_head, pos_q != '0, head_i.valid, "entry left queue mid-walk")

endmodule

### rtl/tmc_uart_slave_framer_unit.sv
// The first result of an item passes through the queue and then the output register.
// Throughput: one input beat per cycle while the two-entry queue has room; results
//   leave one per cycle while out_ready_i is high, one beat for each result of the item.
// An item that yields no result pushes no entry; it waits only while the queue is full.
// Reset (rst_ni low, async): request hunt, reply state, queue and output valid clear;
//   sync bytes and master address return to their defaults. No clearing pass.
module tmc_uart_slave_framer_unit import tmc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Input beats.
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        action_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic              final_item_i,
  // Result beats.
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        kind_o,
  output logic [BYTE_W-1:0] slave_addr_o,
  output logic [BYTE_W-1:0] reg_num_o,
  output logic [BYTE_W-1:0] tx_byte_o,
  output logic              run_last_o,
  // Configuration writes.
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [BYTE_W-1:0] cfg_data_i
);

  tmc_slot_t push;
  tmc_slot_t head;
  logic      q_full;
  logic      pop;

  // Front end: classify each beat, run the request CRC check and the reply
  // CRC, and for a beat that causes results push one entry holding all of them.
  tmc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .data_byte_i  (data_byte_i),
    .final_item_i (final_item_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .q_full_i     (q_full),
    .push_o       (push)
  );

  // Queue: decouple front from back so a stalled output does not block
  // intake until the queue fills.
  tmc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .head_o (head),
    .pop_i  (pop)
  );

  // Back end: serialize each entry into result beats through the output
  // register, marking the last one of the entry.
  tmc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .slave_addr_o (slave_addr_o),
    .reg_num_o    (reg_num_o),
    .tx_byte_o    (tx_byte_o),
    .run_last_o   (run_last_o)
  );

endmodule
